@@ design/cmiou_pkg.sv @@
// ----------------------------------------------------------------------------
// cmiou_pkg
// Shared types, constants and helpers of the confusion matrix IoU accumulator.
// ----------------------------------------------------------------------------
package cmiou_pkg;

  localparam int CLASSES = 32;
  localparam int CLS_W   = 5;
  localparam int ADDR_W  = 2 * CLS_W;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = CNT_W + CLS_W;
  localparam int DEN_W   = SUM_W + 1;
  localparam int RAT_W   = 16;
  localparam int CFG_W   = 6;
  localparam int STEP_W  = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] DSEL_GLOB = 2'd0;
  localparam logic [1:0] DSEL_REC  = 2'd1;
  localparam logic [1:0] DSEL_IOU  = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CLS_W-1:0] target_class;
    logic [CLS_W-1:0] predicted_class;
  } in_t;

  typedef struct packed {
    logic [CLS_W-1:0] class_index;
    logic [CNT_W-1:0] correct_count;
    logic [RAT_W-1:0] class_recall;
    logic [RAT_W-1:0] class_iou;
    logic [RAT_W-1:0] global_accuracy;
    logic             ratio_undefined;
    logic             pair_dropped;
    logic             last_line;
  } out_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              wr_zero;
    logic [ADDR_W-1:0] addr;
    logic              tot_clr;
    logic              tot_inc;
    logic              tot_diag;
    logic              acc_clr;
    logic              tag_row;
    logic              tag_col;
    logic              tag_diag;
    logic              div_start;
    logic              div_store;
    logic [1:0]        div_sel;
    logic              emit_line;
    logic              emit_drop;
    logic [CLS_W-1:0]  line_idx;
    logic              line_last;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

endpackage

@@ design/confusion_matrix_iou_accumulator.sv @@
// ----------------------------------------------------------------------------
// confusion_matrix_iou_accumulator
// Confusion matrix of label pairs with per-class recall and IoU report.
// ----------------------------------------------------------------------------
// After reset the count memory is zeroed by a sweep over all 1024 addresses
// with busy high; a clear item runs the same sweep. A label pair is a
// read-modify-write on the single-port count memory; a dropped pair or an
// unused kind is handled in the idle state. A report forms the global ratio
// and then, per class, makes 2n memory reads for row and column sums and two
// divisions in the shared one-bit-per-cycle divider. Results appear in the
// cycle after they are formed, for one cycle, with out_strobe high, and
// cannot be stalled.
module confusion_matrix_iou_accumulator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  cmiou_pkg::in_t              in_item,
  output logic                        out_strobe,
  output cmiou_pkg::out_t             out_item,
  input  logic                        cfg_we,
  input  logic [cmiou_pkg::CFG_W-1:0] cfg_data
);

  cmiou_pkg::dp_cmd_t cmd;
  cmiou_pkg::dp_sts_t sts;

  cmiou_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .busy     (busy),
    .cmd      (cmd),
    .sts      (sts)
  );

  cmiou_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.pair_dropped |-> out_item.last_line)
    else $error("dropped pair result without last_line");

  a_line_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.pair_dropped |-> $past(busy))
    else $error("report line not produced by a report walk");

  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("block not busy after reset");

endmodule

@@ design/cmiou_div.sv @@
// ----------------------------------------------------------------------------
// cmiou_div
// Restoring divider, one quotient bit per cycle, saturating Q0.16 ratio.
// ----------------------------------------------------------------------------
module cmiou_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [cmiou_pkg::CNT_W-1:0]    num,
  input  logic [cmiou_pkg::DEN_W-1:0]    den,
  output logic                           busy,
  output logic [cmiou_pkg::RAT_W-1:0]    quo
);

  logic [cmiou_pkg::DEN_W:0]    rem_r, rem_nxt, rem2;
  logic [cmiou_pkg::DEN_W-1:0]  den_r;
  logic [cmiou_pkg::RAT_W-1:0]  quo_r, quo_nxt;
  logic [cmiou_pkg::STEP_W-1:0] cnt_r;
  logic                         busy_r;
  logic                         ge;

  always_comb begin
    rem2    = {rem_r[cmiou_pkg::DEN_W-1:0], 1'b0};
    ge      = rem2 >= {1'b0, den_r};
    rem_nxt = ge ? rem2 - {1'b0, den_r} : rem2;
    quo_nxt = {quo_r[cmiou_pkg::RAT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      den_r <= den;
      rem_r <= {{(cmiou_pkg::DEN_W + 1 - cmiou_pkg::CNT_W){1'b0}}, num};
      cnt_r <= cmiou_pkg::STEP_W'(cmiou_pkg::RAT_W - 1);
      if (den == '0) begin
        quo_r  <= '0;
        busy_r <= 1'b0;
      end else if ({{(cmiou_pkg::DEN_W - cmiou_pkg::CNT_W){1'b0}}, num} >= den) begin
        quo_r  <= '1;
        busy_r <= 1'b0;
      end else begin
        quo_r  <= '0;
        busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

@@ design/cmiou_dp.sv @@
// ----------------------------------------------------------------------------
// cmiou_dp
// Datapath: count memory, totals, row/column sums, ratio unit, result register.
// ----------------------------------------------------------------------------
module cmiou_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  cmiou_pkg::dp_cmd_t cmd,
  output cmiou_pkg::dp_sts_t sts,
  output logic               out_strobe,
  output cmiou_pkg::out_t    out_item
);

  localparam int DEPTH = cmiou_pkg::CLASSES * cmiou_pkg::CLASSES;

  logic [cmiou_pkg::CNT_W-1:0] mem [DEPTH];
  logic [cmiou_pkg::CNT_W-1:0] rd_data_r, wr_data;
  logic                        tag_row_r, tag_col_r, tag_diag_r;
  logic [cmiou_pkg::CNT_W-1:0] trace_r, grand_r, diag_r;
  logic [cmiou_pkg::SUM_W-1:0] row_r, col_r;
  logic [cmiou_pkg::RAT_W-1:0] glob_r, rec_r, iou_r;
  logic                        glob_undef_r, undef_r;
  logic                        out_strobe_r;
  cmiou_pkg::out_t             out_r;
  logic [cmiou_pkg::CNT_W-1:0] div_num;
  logic [cmiou_pkg::DEN_W-1:0] div_den, iou_den;
  logic                        div_busy;
  logic [cmiou_pkg::RAT_W-1:0] div_quo;

  assign wr_data = cmd.wr_zero ? '0 : cmiou_pkg::sat_inc(rd_data_r);
  assign iou_den = {1'b0, row_r} + {1'b0, col_r}
                 - {{(cmiou_pkg::DEN_W - cmiou_pkg::CNT_W){1'b0}}, diag_r};

  always_comb begin
    unique case (cmd.div_sel)
      cmiou_pkg::DSEL_GLOB: begin
        div_num = trace_r;
        div_den = {{(cmiou_pkg::DEN_W - cmiou_pkg::CNT_W){1'b0}}, grand_r};
      end
      cmiou_pkg::DSEL_REC: begin
        div_num = diag_r;
        div_den = {1'b0, row_r};
      end
      default: begin
        div_num = diag_r;
        div_den = iou_den;
      end
    endcase
  end

  cmiou_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_row_r    <= 1'b0;
      tag_col_r    <= 1'b0;
      tag_diag_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      trace_r      <= '0;
      grand_r      <= '0;
      glob_undef_r <= 1'b0;
      undef_r      <= 1'b0;
    end else begin
      tag_row_r    <= cmd.tag_row;
      tag_col_r    <= cmd.tag_col;
      tag_diag_r   <= cmd.tag_diag;
      out_strobe_r <= cmd.emit_line | cmd.emit_drop;

      if (cmd.tot_clr) begin
        trace_r <= '0;
        grand_r <= '0;
      end else if (cmd.tot_inc) begin
        grand_r <= cmiou_pkg::sat_inc(grand_r);
        if (cmd.tot_diag) begin
          trace_r <= cmiou_pkg::sat_inc(trace_r);
        end
      end

      if (cmd.acc_clr) begin
        undef_r <= glob_undef_r;
      end else if (cmd.div_start && div_den == '0) begin
        if (cmd.div_sel == cmiou_pkg::DSEL_GLOB) begin
          glob_undef_r <= 1'b1;
        end else begin
          undef_r <= 1'b1;
        end
      end else if (cmd.div_start && cmd.div_sel == cmiou_pkg::DSEL_GLOB) begin
        glob_undef_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      if (tag_row_r) begin
        row_r <= row_r + {{cmiou_pkg::CLS_W{1'b0}}, rd_data_r};
      end
      if (tag_col_r) begin
        col_r <= col_r + {{cmiou_pkg::CLS_W{1'b0}}, rd_data_r};
      end
    end
    if (tag_diag_r) begin
      diag_r <= rd_data_r;
    end

    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        cmiou_pkg::DSEL_GLOB: glob_r <= div_quo;
        cmiou_pkg::DSEL_REC:  rec_r  <= div_quo;
        default:              iou_r  <= div_quo;
      endcase
    end

    if (cmd.emit_drop) begin
      out_r <= '{pair_dropped: 1'b1, last_line: 1'b1, default: '0};
    end else if (cmd.emit_line) begin
      out_r <= '{class_index:     cmd.line_idx,
                 correct_count:   diag_r,
                 class_recall:    rec_r,
                 class_iou:       iou_r,
                 global_accuracy: glob_r,
                 ratio_undefined: undef_r,
                 pair_dropped:    1'b0,
                 last_line:       cmd.line_last};
    end
  end

  assign sts.div_busy = div_busy;
  assign out_strobe   = out_strobe_r;
  assign out_item     = out_r;

endmodule

@@ design/cmiou_ctrl.sv @@
// ----------------------------------------------------------------------------
// cmiou_ctrl
// Controller: item decode, clear sweep, update sequence and report walk.
// ----------------------------------------------------------------------------
module cmiou_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  cmiou_pkg::in_t                in_item,
  input  logic                          cfg_we,
  input  logic [cmiou_pkg::CFG_W-1:0]   cfg_data,
  output logic                          busy,
  output cmiou_pkg::dp_cmd_t            cmd,
  input  cmiou_pkg::dp_sts_t            sts
);

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_ADD_RD = 4'd2;
  localparam logic [3:0] ST_ADD_WR = 4'd3;
  localparam logic [3:0] ST_GDIV   = 4'd4;
  localparam logic [3:0] ST_GWAIT  = 4'd5;
  localparam logic [3:0] ST_CINIT  = 4'd6;
  localparam logic [3:0] ST_SCAN   = 4'd7;
  localparam logic [3:0] ST_DRAIN  = 4'd8;
  localparam logic [3:0] ST_RDIV   = 4'd9;
  localparam logic [3:0] ST_RWAIT  = 4'd10;
  localparam logic [3:0] ST_IDIV   = 4'd11;
  localparam logic [3:0] ST_IWAIT  = 4'd12;
  localparam logic [3:0] ST_EMIT   = 4'd13;

  logic [3:0]                        state_r, state_nxt;
  logic [cmiou_pkg::CFG_W-1:0]       cfg_r;
  logic [cmiou_pkg::ADDR_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [cmiou_pkg::CLS_W-1:0]       t_r, t_nxt, p_r, p_nxt;
  logic [cmiou_pkg::CLS_W-1:0]       c_r, c_nxt, k_r, k_nxt;
  logic                              ph_r, ph_nxt;
  logic [cmiou_pkg::CFG_W-1:0]       n_eff;
  logic [cmiou_pkg::CLS_W-1:0]       n_last;
  logic                              take, drop;

  always_comb begin
    if (cfg_r == '0) begin
      n_eff = cmiou_pkg::CFG_W'(1);
    end else if (cfg_r > cmiou_pkg::CFG_W'(cmiou_pkg::CLASSES)) begin
      n_eff = cmiou_pkg::CFG_W'(cmiou_pkg::CLASSES);
    end else begin
      n_eff = cfg_r;
    end
  end

  assign n_last = cmiou_pkg::CLS_W'(n_eff - 1'b1);
  assign busy   = state_r != ST_IDLE;
  assign take   = start && !busy;
  assign drop   = ({1'b0, in_item.target_class} >= n_eff)
               || ({1'b0, in_item.predicted_class} >= n_eff);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    t_nxt       = t_r;
    p_nxt       = p_r;
    c_nxt       = c_r;
    k_nxt       = k_r;
    ph_nxt      = ph_r;
    cmd         = '0;
    cmd.div_sel = cmiou_pkg::DSEL_GLOB;
    cmd.line_idx = c_r;
    cmd.line_last = c_r == n_last;

    unique case (state_r)
      ST_CLR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_zero = 1'b1;
        cmd.addr    = clr_cnt_r;
        cmd.tot_clr = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          unique case (in_item.kind)
            cmiou_pkg::KIND_ADD: begin
              if (drop) begin
                cmd.emit_drop = 1'b1;
              end else begin
                t_nxt     = in_item.target_class;
                p_nxt     = in_item.predicted_class;
                state_nxt = ST_ADD_RD;
              end
            end
            cmiou_pkg::KIND_REPORT: begin
              c_nxt     = '0;
              state_nxt = ST_GDIV;
            end
            cmiou_pkg::KIND_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_RD: begin
        cmd.rd_en = 1'b1;
        cmd.addr  = {t_r, p_r};
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.addr     = {t_r, p_r};
        cmd.tot_inc  = 1'b1;
        cmd.tot_diag = t_r == p_r;
        state_nxt    = ST_IDLE;
      end
      ST_GDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_GWAIT;
      end
      ST_GWAIT: begin
        if (!sts.div_busy) begin
          cmd.div_store = 1'b1;
          state_nxt     = ST_CINIT;
        end
      end
      ST_CINIT: begin
        cmd.acc_clr = 1'b1;
        k_nxt       = '0;
        ph_nxt      = 1'b0;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (!ph_r) begin
          cmd.addr     = {c_r, k_r};
          cmd.tag_row  = 1'b1;
          cmd.tag_diag = k_r == c_r;
        end else begin
          cmd.addr    = {k_r, c_r};
          cmd.tag_col = 1'b1;
        end
        ph_nxt = !ph_r;
        if (ph_r) begin
          k_nxt = k_r + 1'b1;
          if (k_r == n_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RDIV;
      end
      ST_RDIV: begin
        cmd.div_sel   = cmiou_pkg::DSEL_REC;
        cmd.div_start = 1'b1;
        state_nxt     = ST_RWAIT;
      end
      ST_RWAIT: begin
        cmd.div_sel = cmiou_pkg::DSEL_REC;
        if (!sts.div_busy) begin
          cmd.div_store = 1'b1;
          state_nxt     = ST_IDIV;
        end
      end
      ST_IDIV: begin
        cmd.div_sel   = cmiou_pkg::DSEL_IOU;
        cmd.div_start = 1'b1;
        state_nxt     = ST_IWAIT;
      end
      ST_IWAIT: begin
        cmd.div_sel = cmiou_pkg::DSEL_IOU;
        if (!sts.div_busy) begin
          cmd.div_store = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_line = 1'b1;
        if (c_r == n_last) begin
          state_nxt = ST_IDLE;
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = ST_CINIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_cnt_r <= '0;
      cfg_r     <= cmiou_pkg::CFG_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r  <= t_nxt;
    p_r  <= p_nxt;
    c_r  <= c_nxt;
    k_r  <= k_nxt;
    ph_r <= ph_nxt;
  end

endmodule

@@ test/cmiou_checker.sv @@
// ----------------------------------------------------------------------------
// cmiou_checker
// Watches the item, result and register ports of the confusion matrix IoU
// accumulator. It keeps its own matrix, totals and class count, works out
// the report lines or drop flags that each accepted item should give, and
// compares every strobed result field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module cmiou_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  cmiou_pkg::in_t              in_item,
  input  logic                        out_strobe,
  input  cmiou_pkg::out_t             out_item,
  input  logic                        cfg_we,
  input  logic [cmiou_pkg::CFG_W-1:0] cfg_data,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;
  localparam longint unsigned RAT_MAX = 64'hFFFF;

  logic [cmiou_pkg::CNT_W-1:0] counts [cmiou_pkg::CLASSES*cmiou_pkg::CLASSES];
  longint unsigned             diag_total;
  longint unsigned             pair_total;
  logic [cmiou_pkg::CFG_W-1:0] class_cfg;
  cmiou_pkg::out_t             lines_due [$];

  function automatic longint unsigned q16(longint unsigned num, longint unsigned den);
    if (num >= den) return RAT_MAX;
    return (num << cmiou_pkg::RAT_W) / den;
  endfunction

  function automatic int used_classes();
    if (class_cfg < 1) return 1;
    if (class_cfg > cmiou_pkg::CLASSES) return cmiou_pkg::CLASSES;
    return int'(class_cfg);
  endfunction

  task automatic wipe_matrix();
    for (int i = 0; i < cmiou_pkg::CLASSES*cmiou_pkg::CLASSES; i++) counts[i] = '0;
    diag_total = 0;
    pair_total = 0;
  endtask

  task automatic predict(cmiou_pkg::in_t it);
    int              n;
    longint unsigned glob, diag, row, col, uden;
    logic            glob_undef;
    cmiou_pkg::out_t o;
    n = used_classes();
    o = '0;
    case (it.kind)
      cmiou_pkg::KIND_ADD: begin
        if (it.target_class >= n || it.predicted_class >= n) begin
          o.pair_dropped = 1'b1;
          o.last_line    = 1'b1;
          lines_due.insert(lines_due.size(), o);
        end else begin
          counts[{it.target_class, it.predicted_class}] =
            cmiou_pkg::sat_inc(counts[{it.target_class, it.predicted_class}]);
          if (it.target_class == it.predicted_class && diag_total < CNT_MAX)
            diag_total++;
          if (pair_total < CNT_MAX) pair_total++;
        end
      end
      cmiou_pkg::KIND_CLEAR: wipe_matrix();
      cmiou_pkg::KIND_REPORT: begin
        glob_undef = (pair_total == 0);
        glob = glob_undef ? 0 : q16(diag_total, pair_total);
        for (int c = 0; c < n; c++) begin
          diag = counts[c*cmiou_pkg::CLASSES + c];
          row = 0;
          col = 0;
          for (int k = 0; k < n; k++) begin
            row += counts[c*cmiou_pkg::CLASSES + k];
            col += counts[k*cmiou_pkg::CLASSES + c];
          end
          uden = row + col - diag;
          o = '0;
          o.class_index     = c[cmiou_pkg::CLS_W-1:0];
          o.correct_count   = diag[cmiou_pkg::CNT_W-1:0];
          o.class_recall    = (row == 0) ? '0 : q16(diag, row);
          o.class_iou       = (uden == 0) ? '0 : q16(diag, uden);
          o.global_accuracy = glob[cmiou_pkg::RAT_W-1:0];
          o.ratio_undefined = glob_undef || row == 0 || uden == 0;
          o.last_line       = (c == n - 1);
          lines_due.insert(lines_due.size(), o);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, longint unsigned exp, longint unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    cmiou_pkg::out_t e;
    if (!rst_n) begin
      wipe_matrix();
      class_cfg = cmiou_pkg::CFG_RESET;
      lines_due.delete();
    end else begin
      if (start && !busy) predict(in_item);
      if (cfg_we) class_cfg = cfg_data;
      if (out_strobe) begin
        if (lines_due.size() == 0) begin
          $error("result with nothing expected: class_index %0d", out_item.class_index);
          errors++;
        end else begin
          e = lines_due[0];
          lines_due.delete(0);
          check_field("class_index", e.class_index, out_item.class_index);
          check_field("correct_count", e.correct_count, out_item.correct_count);
          check_field("class_recall", e.class_recall, out_item.class_recall);
          check_field("class_iou", e.class_iou, out_item.class_iou);
          check_field("global_accuracy", e.global_accuracy, out_item.global_accuracy);
          check_field("ratio_undefined", e.ratio_undefined, out_item.ratio_undefined);
          check_field("pair_dropped", e.pair_dropped, out_item.pair_dropped);
          check_field("last_line", e.last_line, out_item.last_line);
        end
      end
    end
    pending = lines_due.size();
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives label pairs, reports, clears, unused-kind items and class count
// changes into the confusion matrix IoU accumulator with random gaps; the
// checker beside the block predicts and compares, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         LIMIT      = 2_000_000;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  cmiou_pkg::in_t              in_item;
  logic                        out_strobe;
  cmiou_pkg::out_t             out_item;
  logic                        cfg_we;
  logic [cmiou_pkg::CFG_W-1:0] cfg_data;
  int                          errors;
  int                          pending;
  int                          cycles;

  confusion_matrix_iou_accumulator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  cmiou_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [cmiou_pkg::CLS_W-1:0] rand_cls();
    return cmiou_pkg::CLS_W'($urandom);
  endfunction

  task automatic send_item(logic [1:0] kind, logic [cmiou_pkg::CLS_W-1:0] t,
                           logic [cmiou_pkg::CLS_W-1:0] p);
    int gap;
    in_item <= '{kind: kind, target_class: t, predicted_class: p};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drained and quiet for a while before touching the register
  task automatic wait_quiet();
    int calm;
    start <= 1'b0;
    calm = 0;
    while (calm < 8) begin
      @(posedge clk);
      calm = (pending == 0 && !busy) ? calm + 1 : 0;
    end
  endtask

  task automatic write_classes(logic [cmiou_pkg::CFG_W-1:0] v);
    wait_quiet();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(logic [cmiou_pkg::CFG_W-1:0] v, int items);
    int n, r;
    logic [cmiou_pkg::CLS_W-1:0] t, p;
    write_classes(v);
    n = (v < 1) ? 1 : (v > cmiou_pkg::CLASSES) ? cmiou_pkg::CLASSES : int'(v);
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 88) begin
        if ($urandom_range(0, 9) == 0) begin
          t = rand_cls();
          p = rand_cls();
        end else begin
          t = cmiou_pkg::CLS_W'($urandom_range(0, n - 1));
          p = ($urandom_range(0, 2) == 0) ?
              cmiou_pkg::CLS_W'($urandom_range(0, n - 1)) : t;
        end
        send_item(cmiou_pkg::KIND_ADD, t, p);
      end else if (r < 93) begin
        send_item(cmiou_pkg::KIND_REPORT, rand_cls(), rand_cls());
      end else if (r < 95) begin
        send_item(cmiou_pkg::KIND_CLEAR, rand_cls(), rand_cls());
      end else begin
        send_item(KIND_SPARE, rand_cls(), rand_cls());
      end
    end
    send_item(cmiou_pkg::KIND_REPORT, rand_cls(), rand_cls());
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_item  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    cycles   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(cmiou_pkg::KIND_REPORT, 5'd0, 5'd0);
    send_item(cmiou_pkg::KIND_ADD, 5'd0, 5'd0);
    send_item(cmiou_pkg::KIND_ADD, 5'd31, 5'd31);
    send_item(cmiou_pkg::KIND_ADD, 5'd0, 5'd31);
    send_item(cmiou_pkg::KIND_ADD, 5'd31, 5'd0);
    send_item(cmiou_pkg::KIND_ADD, 5'd21, 5'd10);
    send_item(cmiou_pkg::KIND_ADD, 5'd10, 5'd21);
    send_item(KIND_SPARE, 5'd31, 5'd31);
    send_item(cmiou_pkg::KIND_REPORT, 5'd31, 5'd31);
    write_classes(6'd2);
    send_item(cmiou_pkg::KIND_ADD, 5'd2, 5'd0);
    send_item(cmiou_pkg::KIND_ADD, 5'd0, 5'd2);
    send_item(cmiou_pkg::KIND_ADD, 5'd1, 5'd1);
    send_item(cmiou_pkg::KIND_REPORT, 5'd0, 5'd0);
    send_item(cmiou_pkg::KIND_CLEAR, 5'd0, 5'd0);
    send_item(cmiou_pkg::KIND_REPORT, 5'd0, 5'd0);
    write_classes(6'd0);
    send_item(cmiou_pkg::KIND_ADD, 5'd1, 5'd0);
    send_item(cmiou_pkg::KIND_ADD, 5'd0, 5'd0);
    send_item(cmiou_pkg::KIND_REPORT, 5'd0, 5'd0);
    write_classes(6'd63);
    send_item(cmiou_pkg::KIND_REPORT, 5'd0, 5'd0);

    random_phase(6'd32, 90);
    random_phase(6'd2, 60);
    random_phase(6'd63, 70);
    random_phase(6'd1, 30);
    random_phase(6'd0, 30);
    random_phase(6'd17, 70);
    random_phase(cmiou_pkg::CFG_W'($urandom_range(2, 31)), 70);
    random_phase(cmiou_pkg::CFG_W'($urandom_range(0, 63)), 70);

    wait_quiet();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/cmiou_pkg.sv
design/cmiou_div.sv
design/cmiou_dp.sv
design/cmiou_ctrl.sv
design/confusion_matrix_iou_accumulator.sv
test/cmiou_checker.sv
test/testbench.sv
